// File: hdl/egcd_pkg.sv
`default_nettype none

package egcd_pkg;

    // default operand width
    localparam int OPERAND_WIDTH_DEF = 31;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_DONE
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;    // capture operands
        logic init;    // set up one remainder step
        logic step;    // one bit of the remainder
        logic finish;  // latch the result
    } t_dp_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic a_zero;
        logic b_zero;
        logic cnt_zero;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: hdl/euclid_gcd_modulo.sv
// channel  | transfer when         | ports
// ---------+-----------------------+------------------------------------------
// operands | start && !busy        | i_first_operand, i_second_operand
// result   | o_valid (one cycle)   | o_divisor_result
//
// one operand pair at a time; busy is high from the transfer until the result
// the number of remainder steps per operand pair is at most about 45 at W=31
// each remainder step runs W bits through one shared restoring remainder unit
// reset (i_rst_n low, synchronous) returns the sequencer to idle, no result
// the result strobe lasts one cycle and cannot be held off by the receiver
`default_nettype none

module euclid_gcd_modulo #(
    parameter int OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      start,
    output logic                     busy,
    input  wire [OPERAND_WIDTH-1:0]  i_first_operand,
    input  wire [OPERAND_WIDTH-1:0]  i_second_operand,
    output logic [OPERAND_WIDTH-1:0] o_divisor_result,
    output logic                     o_valid
);
    import egcd_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencer
    egcd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    // operand registers and remainder unit
    egcd_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .o_stat           (stat),
        .o_divisor_result (o_divisor_result)
    );

endmodule

`default_nettype wire

// File: hdl/egcd_ctrl.sv
`default_nettype none

module egcd_ctrl (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      start,
    input  wire egcd_pkg::t_dp_stat  i_stat,
    output egcd_pkg::t_dp_cmd        o_cmd,
    output logic                     busy,
    output logic                     o_valid
);
    import egcd_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.a_zero || i_stat.b_zero) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.cnt_zero) begin
                    n_state = S_CHECK;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        busy    = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_cmd.load = start;
            end
            S_CHECK: begin
                if (i_stat.a_zero || i_stat.b_zero) begin
                    o_cmd.finish = 1'b1;
                end else begin
                    o_cmd.init = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
            end
            S_DONE: begin
                o_valid = 1'b1;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

`ifndef SYNTHESIS
    // result strobe lasts one cycle
    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");

    // a transfer makes the block busy next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy && !o_valid)) else $error("accepted item not taken up");

    // a finished operand pair produces the strobe next cycle
    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> o_valid) else $error("finish without result strobe");
`endif

endmodule

`default_nettype wire

// File: hdl/egcd_dp.sv
`default_nettype none

module egcd_dp #(
    parameter int OPERAND_WIDTH = egcd_pkg::OPERAND_WIDTH_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire egcd_pkg::t_dp_cmd   i_cmd,
    input  wire [OPERAND_WIDTH-1:0]  i_first_operand,
    input  wire [OPERAND_WIDTH-1:0]  i_second_operand,
    output egcd_pkg::t_dp_stat       o_stat,
    output logic [OPERAND_WIDTH-1:0] o_divisor_result
);
    import egcd_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W);

    logic [W-1:0]     r_a;
    logic [W-1:0]     r_b;
    logic [W-1:0]     r_num;
    logic [W-1:0]     r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_sel;      // 1: a takes a mod b, 0: b takes b mod a
    logic [W-1:0]     r_result;

    logic [W:0]       n_trial;
    logic [W-1:0]     den;
    logic [W-1:0]     n_rem;

    // one restoring bit of the remainder
    always_comb begin
        den     = r_sel ? r_b : r_a;
        n_trial = {r_rem, r_num[W-1]};
        if (n_trial >= {1'b0, den}) begin
            n_rem = W'(n_trial - {1'b0, den});
        end else begin
            n_rem = n_trial[W-1:0];
        end
    end

    // operand and remainder registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a <= i_first_operand;
            r_b <= i_second_operand;
        end
        if (i_cmd.init) begin
            r_sel <= (r_a > r_b);
            r_num <= (r_a > r_b) ? r_a : r_b;
            r_rem <= '0;
            r_cnt <= CNT_W'(W - 1);
        end
        if (i_cmd.step) begin
            r_rem <= n_rem;
            r_num <= {r_num[W-2:0], 1'b0};
            r_cnt <= r_cnt - 1'b1;
            // last bit: write remainder back over the larger operand
            if (r_cnt == '0) begin
                if (r_sel) begin
                    r_a <= n_rem;
                end else begin
                    r_b <= n_rem;
                end
            end
        end
        if (i_cmd.finish) begin
            r_result <= (r_a == '0) ? r_b : r_a;
        end
    end

    // status to controller
    always_comb begin
        o_stat.a_zero   = (r_a == '0);
        o_stat.b_zero   = (r_b == '0);
        o_stat.cnt_zero = (r_cnt == '0);
    end

    assign o_divisor_result = r_result;

`ifndef SYNTHESIS
    // a remainder step never starts with a zero divisor
    a_init_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.init |-> (r_a != '0 && r_b != '0)) else $error("remainder by zero");

    // the written-back remainder is below its divisor
    a_rem_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && r_cnt == '0) |=>
        ((r_sel && r_a < r_b) || (!r_sel && r_b < r_a)))
        else $error("remainder not below divisor");

    // selection holds through the bits of one step
    a_sel_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step && $past(i_cmd.step)) |-> $stable(r_sel))
        else $error("divisor selection changed mid step");
`endif

endmodule

`default_nettype wire

// File: dv/tb_euclid_gcd_modulo.sv
`timescale 1ns / 100ps

module tb_euclid_gcd_modulo;

    localparam int OPW = egcd_pkg::OPERAND_WIDTH_DEF;
    localparam logic [OPW-1:0] OP_MAX = '1;
    localparam int RANDOM_PAIRS = 1380;
    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int REPORT_LIMIT = 10;
    localparam int NUM_DIRECTED = 20;

    // one directed operand pair; gcd is used only when typed is set
    typedef struct packed {
        logic [OPW-1:0] first;
        logic [OPW-1:0] second;
        logic           typed;
        logic [OPW-1:0] gcd;
    } t_pair_row;

    t_pair_row directed_pairs [NUM_DIRECTED] = '{
        '{0, 0, 1'b1, 0},                                   // both zero
        '{0, OP_MAX, 1'b1, OP_MAX},                         // first zero
        '{OP_MAX, 0, 1'b1, OP_MAX},                         // second zero
        '{OP_MAX, OP_MAX, 1'b1, OP_MAX},                    // equal at max
        '{1, OP_MAX, 1'b1, 1},
        '{OP_MAX, 1, 1'b1, 1},
        '{1, 1, 1'b1, 1},
        '{0, 1, 1'b1, 1},
        '{OP_MAX, OP_MAX - 1, 1'b1, 1},
        '{48, 18, 1'b1, 6},
        '{18, 48, 1'b1, 6},
        '{12345, 12345, 1'b1, 12345},                       // equal operands
        '{31'h2AAAAAAA, 31'h55555555, 1'b0, 0},
        '{31'h40000000, 31'h20000000, 1'b1, 31'h20000000},
        '{1836311903, 1134903170, 1'b0, 0},                 // longest remainder chain
        '{1134903170, 1836311903, 1'b0, 0},
        '{2, OP_MAX - 1, 1'b1, 2},
        '{OP_MAX - 1, OP_MAX >> 1, 1'b1, OP_MAX >> 1},
        '{31'h0F0F0F0F, 31'h70F0F0F0, 1'b0, 0},
        '{OP_MAX, 31'h40000000, 1'b1, 1}                    // max is prime
    };

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    logic [OPW-1:0] i_first_operand;
    logic [OPW-1:0] i_second_operand;
    logic [OPW-1:0] o_divisor_result;
    logic           o_valid;

    logic [OPW-1:0] pending_divisors [$];
    logic [63:0]    fib_seq [0:46];
    int             pairs_sent;
    int             divisors_checked;
    int             common_factor_hits;
    int             fail_count;
    int             cycle_count;
    int             no_idle_left;

    euclid_gcd_modulo #(
        .OPERAND_WIDTH(OPW)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_first_operand  (i_first_operand),
        .i_second_operand (i_second_operand),
        .o_divisor_result (o_divisor_result),
        .o_valid          (o_valid)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // gcd by repeated remainder of the larger operand
    function automatic logic [OPW-1:0] gcd_by_remainder(logic [OPW-1:0] first,
                                                        logic [OPW-1:0] second);
        logic [OPW-1:0] x;
        logic [OPW-1:0] y;
        x = first;
        y = second;
        while (x != 0 && y != 0) begin
            if (x > y) begin
                x = x % y;
            end else begin
                y = y % x;
            end
        end
        return (x == 0) ? y : x;
    endfunction

    task automatic note_mismatch(input string what, input logic [OPW-1:0] want,
                                 input logic [OPW-1:0] got);
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
            $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
        end
    endtask

    // sender idle length: mostly none or short, some long, bursts with none
    function automatic int pick_gap();
        int r;
        if (no_idle_left > 0) begin
            no_idle_left--;
            return 0;
        end
        if ($urandom_range(0, 49) == 0) begin
            no_idle_left = $urandom_range(20, 60);
        end
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 150);
    endfunction

    // random operand pair from a mix of shapes
    task automatic draw_pair(output logic [OPW-1:0] a, output logic [OPW-1:0] b);
        logic [63:0]    g;
        logic [63:0]    m;
        logic [OPW-1:0] t;
        int             kind;
        int             n;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            // full width
            a = OPW'($urandom);
            b = OPW'($urandom);
        end else if (kind < 55) begin
            // shared factor so the gcd is nontrivial
            g = 64'($urandom_range(2, 100000));
            a = OPW'(g * $urandom_range(0, 32'((OP_MAX / g) >> $urandom_range(0, 20))));
            b = OPW'(g * $urandom_range(0, 32'((OP_MAX / g) >> $urandom_range(0, 20))));
        end else if (kind < 75) begin
            a = OPW'($urandom_range(0, 255));
            b = OPW'($urandom_range(0, 255));
        end else if (kind < 85) begin
            // zero or equal operands
            a = OPW'($urandom >> $urandom_range(0, 31));
            n = $urandom_range(0, 2);
            b = (n == 0) ? a : '0;
        end else if (kind < 90) begin
            // consecutive fibonacci numbers times a factor: long remainder chains
            n = $urandom_range(1, 45);
            m = 64'($urandom_range(1, 32'(OP_MAX / fib_seq[n+1])));
            a = OPW'(fib_seq[n+1] * m);
            b = OPW'(fib_seq[n] * m);
        end else begin
            a = OPW'($urandom >> $urandom_range(0, 30));
            b = OPW'($urandom >> $urandom_range(0, 30));
        end
        if ($urandom_range(0, 1) == 1) begin
            t = a;
            a = b;
            b = t;
        end
    endtask

    // hold one pair on the ports until the transfer, then record its gcd
    task automatic transfer_pair(input logic [OPW-1:0] a, input logic [OPW-1:0] b,
                                 input logic typed, input logic [OPW-1:0] typed_gcd);
        i_first_operand  <= a;
        i_second_operand <= b;
        start            <= 1'b1;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_divisors.push_back(typed ? typed_gcd : gcd_by_remainder(a, b));
        pairs_sent++;
    endtask

    task automatic sender_idle();
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sender stops until every outstanding result has come back
    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_divisors.size() != 0);
    endtask

    // result check
    always @(posedge i_clk) begin : result_check
        logic [OPW-1:0] want;
        if (o_valid === 1'b1) begin
            if (pending_divisors.size() == 0) begin
                note_mismatch("result with no pair outstanding", '0, o_divisor_result);
            end else begin
                want = pending_divisors.pop_front();
                if (o_divisor_result !== want) begin
                    note_mismatch("divisor_result", want, o_divisor_result);
                end
                if (want > 1) begin
                    common_factor_hits++;
                end
                divisors_checked++;
            end
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("euclid_gcd_modulo: mismatch");
            $finish;
        end
    end

    // stimulus
    initial begin : stimulus
        logic [OPW-1:0] a;
        logic [OPW-1:0] b;
        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_first_operand    = '0;
        i_second_operand   = '0;
        pairs_sent         = 0;
        divisors_checked   = 0;
        common_factor_hits = 0;
        fail_count         = 0;
        cycle_count        = 0;
        no_idle_left       = 0;
        fib_seq[0] = 0;
        fib_seq[1] = 1;
        for (int i = 2; i <= 46; i++) begin
            fib_seq[i] = fib_seq[i-1] + fib_seq[i-2];
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pairs
        foreach (directed_pairs[i]) begin
            transfer_pair(directed_pairs[i].first, directed_pairs[i].second,
                          directed_pairs[i].typed, directed_pairs[i].gcd);
            sender_idle();
        end
        drain_results();

        // random pairs
        for (int i = 0; i < RANDOM_PAIRS; i++) begin
            draw_pair(a, b);
            transfer_pair(a, b, 1'b0, '0);
            if (i == RANDOM_PAIRS / 2) begin
                drain_results();
            end else begin
                sender_idle();
            end
        end

        // wait out the last results, then look for stray strobes
        drain_results();
        repeat (64) @(posedge i_clk);

        $display("covered %0d operand pairs (%0d directed), %0d results checked, %0d with gcd > 1",
                 pairs_sent, NUM_DIRECTED, divisors_checked, common_factor_hits);
        $display("zero, equal, extreme and long fibonacci chains included, %0d cycles",
                 cycle_count);
        if (fail_count == 0 && pending_divisors.size() == 0) begin
            $display("euclid_gcd_modulo: match");
        end else begin
            $display("euclid_gcd_modulo: mismatch");
        end
        $finish;
    end

endmodule
